// ----- hdl/qfe_pkg.sv -----
package qfe_pkg;

   localparam int unsigned FRAME_LEN   = 16;
   localparam int unsigned HEAD_LEN    = 14;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0]  SYNC_BYTE  = 8'hA5;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  YEAR_BIAS  = 8'd156;   // minus 100, modulo 256

   // Frame positions that the back end treats specially.
   localparam logic [3:0] POS_SYNC      = 4'd0;
   localparam logic [3:0] POS_CHECK_END = 4'd13;
   localparam logic [3:0] POS_CHECK_HI  = 4'd14;
   localparam logic [3:0] POS_CHECK_LO  = 4'd15;

   typedef enum logic [1:0] {
      LAYOUT_EMPTY    = 2'd0,
      LAYOUT_ID_ATTRS = 2'd1,
      LAYOUT_ID_ONLY  = 2'd2,
      LAYOUT_DATETIME = 2'd3
   } layout_type;

   // Bytes 0..13 of a frame; index 0 is the sync byte.
   typedef logic [HEAD_LEN-1:0][7:0] head_type;

   // Queue status seen by the front and the back end.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // One byte of the check: eight rotating steps of the reflected polynomial.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] crc;
      logic [7:0]  t;
      crc = crc_in;
      t   = crc_in[7:0] ^ data;
      for (int k = 0; k < 8; k++) begin
         if (t[0]) begin
            crc = crc ^ CRC_POLY;
         end
         crc = {crc[0], crc[15:1]};
         t   = {1'b0, t[7:1]};
      end
      return crc;
   endfunction

endpackage

// ----- hdl/qfe_front.sv -----
module qfe_front
   import qfe_pkg::*;
(
   input  logic [1:0]  cmd,
   input  logic [7:0]  command_code,
   input  logic [7:0]  slave_addr,
   input  logic [31:0] card_id,
   input  logic [31:0] credential_attrs,
   input  logic [5:0]  seconds,
   input  logic [5:0]  minutes,
   input  logic [4:0]  hours,
   input  logic [2:0]  weekday,
   input  logic [4:0]  day_of_month,
   input  logic [3:0]  month_index,
   input  logic [8:0]  years_since_1900,
   output head_type    head
);

   layout_type layout;

   assign layout = layout_type'(cmd);

   // Build the fixed part of the frame and lay out the payload by command.
   always_comb begin
      head    = '0;
      head[0] = SYNC_BYTE;
      head[1] = slave_addr;
      head[2] = command_code;
      unique case (layout)
         LAYOUT_ID_ATTRS: begin
            head[3]  = card_id[31:24];
            head[4]  = card_id[23:16];
            head[5]  = card_id[15:8];
            head[6]  = card_id[7:0];
            head[7]  = credential_attrs[31:24];
            head[8]  = credential_attrs[23:16];
            head[9]  = credential_attrs[15:8];
            head[10] = credential_attrs[7:0];
         end
         LAYOUT_ID_ONLY: begin
            head[3] = card_id[31:24];
            head[4] = card_id[23:16];
            head[5] = card_id[15:8];
            head[6] = card_id[7:0];
         end
         LAYOUT_DATETIME: begin
            head[3] = {2'b00, seconds};
            head[4] = {2'b00, minutes};
            head[5] = {3'b000, hours};
            head[6] = {5'b00000, weekday};
            head[7] = {3'b000, day_of_month};
            head[8] = {4'b0000, month_index} + 8'd1;
            head[9] = years_since_1900[7:0] + YEAR_BIAS;
         end
         default: begin
            // The empty layout sends an all-zero payload.
         end
      endcase
   end

endmodule

// ----- hdl/qfe_queue.sv -----
module qfe_queue
   import qfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  head_type         push_head,
   input  logic             pop,
   output head_type         pop_head,
   output queue_status_type status
);

   head_type    mem [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign status.full      = (count_ff == 2'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != 2'd0);
   assign pop_head         = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for the queued frame heads.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_head;
      end
   end

endmodule

// ----- hdl/qfe_back.sv -----
module qfe_back
   import qfe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  head_type         pop_head,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic        busy_ff, busy_in;
   logic [3:0]  pos_ff, pos_in;
   head_type    head_ff, head_in;
   logic [15:0] crc_ff, crc_in;
   logic        fire;
   logic        load;

   assign fire      = busy_ff && out_ready;
   assign load      = !busy_ff || (fire && (pos_ff == POS_CHECK_LO));
   assign pop       = load && status.not_empty;
   assign out_valid = busy_ff;
   assign out_last  = (pos_ff == POS_CHECK_LO);

   // Current byte: stored head bytes, then the check high and low bytes.
   always_comb begin
      case (pos_ff)
         POS_CHECK_HI: out_byte = crc_ff[15:8];
         POS_CHECK_LO: out_byte = crc_ff[7:0];
         default:      out_byte = head_ff[pos_ff];
      endcase
   end

   // Sequencing and running check.
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      head_in = head_ff;
      crc_in  = crc_ff;
      if (fire) begin
         pos_in = pos_ff + 4'd1;
         if ((pos_ff != POS_SYNC) && (pos_ff <= POS_CHECK_END)) begin
            crc_in = crc_byte(crc_ff, out_byte);
         end
      end
      if (load) begin
         busy_in = status.not_empty;
         pos_in  = POS_SYNC;
         head_in = pop_head;
         crc_in  = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_SYNC;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      head_ff <= head_in;
      crc_ff  <= crc_in;
   end

endmodule

// ----- hdl/query_frame_encoder_crc16.sv -----
// Query frame encoder.
// An item on the req_ channel describes one query; the block answers on
// the rsp_ channel with the 16 bytes of its frame, one item per byte,
// from the sync byte to the second check byte, with rsp_last high on
// the final byte.
// The front end formats bytes 0..13 in the cycle the item is accepted
// and places them in a two-entry queue. The back end sends one byte per
// cycle while the receiver is ready and folds bytes 1..13 into the check
// as they leave, one byte of the check per cycle, so the check bytes
// follow directly. When the back end is free, an accepted item passes
// through the queue and the back-end registers before its first byte is
// shown. The queue takes a new item while a frame is still being sent,
// so frames follow each other without a gap.
// If the receiver stalls, the current byte holds and, once the queue is
// full, req_ready falls.
// Reset empties the queue and drops any frame in progress.
module query_frame_encoder_crc16
   import qfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_command_code,
   input  logic [7:0]  req_slave_addr,
   input  logic [31:0] req_card_id,
   input  logic [31:0] req_credential_attrs,
   input  logic [5:0]  req_seconds,
   input  logic [5:0]  req_minutes,
   input  logic [4:0]  req_hours,
   input  logic [2:0]  req_weekday,
   input  logic [4:0]  req_day_of_month,
   input  logic [3:0]  req_month_index,
   input  logic [8:0]  req_years_since_1900,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last
);

   head_type         head;
   head_type         pop_head;
   queue_status_type status;
   logic             pop;
   logic             push;

   assign req_ready = !status.full;
   assign push      = req_valid && req_ready;

   qfe_front u_front (
      .cmd              (req_cmd),
      .command_code     (req_command_code),
      .slave_addr       (req_slave_addr),
      .card_id          (req_card_id),
      .credential_attrs (req_credential_attrs),
      .seconds          (req_seconds),
      .minutes          (req_minutes),
      .hours            (req_hours),
      .weekday          (req_weekday),
      .day_of_month     (req_day_of_month),
      .month_index      (req_month_index),
      .years_since_1900 (req_years_since_1900),
      .head             (head)
   );

   qfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_head (head),
      .pop       (pop),
      .pop_head  (pop_head),
      .status    (status)
   );

   qfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .pop_head  (pop_head),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_byte  (rsp_frame_byte),
      .out_last  (rsp_last)
   );

endmodule

// ----- hdl/qfe_checker.sv -----
module qfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last
);

   logic [3:0] seen_ff;

   // Position of the next result byte within its frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 4'd0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= seen_ff + 4'd1;
      end
   end

   // A stalled byte holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last))
      else $error("stalled result byte changed");

   // The last mark falls on every sixteenth byte and nowhere else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (seen_ff == 4'd15)))
      else $error("last mark out of place");

   // Each frame opens with the sync byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (seen_ff == 4'd0) |-> (rsp_frame_byte == 8'hA5))
      else $error("frame does not start with sync byte");

   // Nothing is shown right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown after reset");

   // The queue has room again after reset.
   assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready after reset");

endmodule

bind query_frame_encoder_crc16 qfe_checker u_qfe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_last       (rsp_last)
);

// ----- tb/tb_query_frame_encoder_crc16.sv -----
`timescale 1ns / 100ps

module tb_query_frame_encoder_crc16;
   import qfe_pkg::*;

   localparam int RANDOM_QUERIES = 320;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 40;

   // One query as it is presented on the request channel.
   typedef struct {
      layout_type  cmd;
      logic [7:0]  command_code;
      logic [7:0]  slave_addr;
      logic [31:0] card_id;
      logic [31:0] credential_attrs;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month_index;
      logic [8:0]  years_since_1900;
   } query_type;

   // A directed row; where has_head is set, bytes 0..13 are typed in by hand.
   typedef struct {
      query_type q;
      bit        has_head;
      head_type  head;
   } query_row_type;

   typedef struct {
      logic [7:0] frame_byte;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [7:0]  req_command_code;
   logic [7:0]  req_slave_addr;
   logic [31:0] req_card_id;
   logic [31:0] req_credential_attrs;
   logic [5:0]  req_seconds;
   logic [5:0]  req_minutes;
   logic [4:0]  req_hours;
   logic [2:0]  req_weekday;
   logic [4:0]  req_day_of_month;
   logic [3:0]  req_month_index;
   logic [8:0]  req_years_since_1900;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last;

   query_row_type  directed_rows[$];
   frame_byte_type frame_bytes_due[$];
   int             mismatches    = 0;
   int             queries_sent  = 0;
   int             bytes_checked = 0;
   int             frames_seen   = 0;
   int             ready_hold    = 0;
   int             ready_pick;
   int             idle_cycles   = 0;
   bit             steady        = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   query_frame_encoder_crc16 dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_command_code     (req_command_code),
      .req_slave_addr       (req_slave_addr),
      .req_card_id          (req_card_id),
      .req_credential_attrs (req_credential_attrs),
      .req_seconds          (req_seconds),
      .req_minutes          (req_minutes),
      .req_hours            (req_hours),
      .req_weekday          (req_weekday),
      .req_day_of_month     (req_day_of_month),
      .req_month_index      (req_month_index),
      .req_years_since_1900 (req_years_since_1900),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_byte       (rsp_frame_byte),
      .rsp_last             (rsp_last)
   );

   // Lay out bytes 0..13 of the frame for a query.
   function automatic head_type format_head(input query_type q);
      head_type h;
      h    = '0;
      h[0] = SYNC_BYTE;
      h[1] = q.slave_addr;
      h[2] = q.command_code;
      case (q.cmd)
         LAYOUT_ID_ATTRS: begin
            {h[3], h[4], h[5], h[6]}  = q.card_id;
            {h[7], h[8], h[9], h[10]} = q.credential_attrs;
         end
         LAYOUT_ID_ONLY: begin
            {h[3], h[4], h[5], h[6]} = q.card_id;
         end
         LAYOUT_DATETIME: begin
            h[3] = {2'b00, q.seconds};
            h[4] = {2'b00, q.minutes};
            h[5] = {3'b000, q.hours};
            h[6] = {5'b00000, q.weekday};
            h[7] = {3'b000, q.day_of_month};
            h[8] = {4'b0000, q.month_index} + 8'd1;
            // The year is sent relative to 2000 and simply wraps outside its range.
            h[9] = q.years_since_1900[7:0] - 8'd100;
         end
         default: begin
         end
      endcase
      return h;
   endfunction

   // Reflected 16-bit check over bytes 1..13, rotating rather than shifting.
   function automatic logic [15:0] frame_check(input head_type h);
      logic [15:0] crc;
      logic [7:0]  t;
      crc = CRC_INIT;
      for (int k = 1; k < HEAD_LEN; k++) begin
         t = crc[7:0] ^ h[k];
         for (int b = 0; b < 8; b++) begin
            if (t[0]) begin
               crc = crc ^ CRC_POLY;
            end
            crc = {crc[0], crc[15:1]};
            t   = t >> 1;
         end
      end
      return crc;
   endfunction

   // Queue the sixteen bytes that a query must produce.
   function automatic void expect_frame(input head_type h);
      logic [15:0] crc;
      crc = frame_check(h);
      for (int k = 0; k < HEAD_LEN; k++) begin
         frame_bytes_due.push_back('{h[k], 1'b0});
      end
      frame_bytes_due.push_back('{crc[15:8], 1'b0});
      frame_bytes_due.push_back('{crc[7:0], 1'b1});
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Random query: mostly legal field values, sometimes the full field width.
   function automatic query_type random_query();
      query_type q;
      bit        wide;
      int        r;
      wide               = ($urandom_range(0, 4) == 0);
      r                  = $urandom_range(0, 15);
      q.cmd              = layout_type'($urandom_range(0, 3));
      q.command_code     = 8'($urandom);
      q.slave_addr       = 8'($urandom);
      q.card_id          = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      q.credential_attrs = (r == 2) ? 32'h0 : (r == 3) ? 32'hFFFF_FFFF : $urandom;
      q.seconds          = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
      q.minutes          = 6'(wide ? $urandom_range(0, 63) : $urandom_range(0, 59));
      q.hours            = 5'(wide ? $urandom_range(0, 31) : $urandom_range(0, 23));
      q.weekday          = 3'(wide ? $urandom_range(0, 7) : $urandom_range(0, 6));
      q.day_of_month     = 5'(wide ? $urandom_range(0, 31) : $urandom_range(1, 31));
      q.month_index      = 4'(wide ? $urandom_range(0, 15) : $urandom_range(0, 11));
      q.years_since_1900 = 9'(wide ? $urandom_range(0, 511) : $urandom_range(100, 355));
      return q;
   endfunction

   task automatic drive_fields(input query_type q);
      req_cmd              <= q.cmd;
      req_command_code     <= q.command_code;
      req_slave_addr       <= q.slave_addr;
      req_card_id          <= q.card_id;
      req_credential_attrs <= q.credential_attrs;
      req_seconds          <= q.seconds;
      req_minutes          <= q.minutes;
      req_hours            <= q.hours;
      req_weekday          <= q.weekday;
      req_day_of_month     <= q.day_of_month;
      req_month_index      <= q.month_index;
      req_years_since_1900 <= q.years_since_1900;
   endtask

   task automatic add_row(input query_type q, input bit has_head, input head_type head);
      directed_rows.push_back('{q, has_head, head});
   endtask

   // Offer one item, optionally after an idle gap, and record its frame once taken.
   // Valid is left high afterwards so that a following item can go straight out.
   task automatic send_query(input query_type q, input bit has_head, input head_type head);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         drive_fields(random_query());
         repeat (gap) @(posedge clock);
      end
      drive_fields(q);
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expect_frame(has_head ? head : format_head(q));
      queries_sent++;
   endtask

   // Receiver: ready in runs, with short stalls and the odd long one.
   always @(posedge clock) begin
      if (steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold == 0) begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 55) begin
            rsp_ready  <= 1'b1;
            ready_hold = $urandom_range(0, 8);
         end else if (ready_pick < 92) begin
            rsp_ready  <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold = $urandom_range(10, 60);
         end
      end else begin
         ready_hold--;
      end
   end

   // Compare every accepted frame byte with the oldest one still due.
   always @(posedge clock) begin : frame_check_monitor
      frame_byte_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (rsp_last) begin
            frames_seen++;
         end
         if (frame_bytes_due.size() == 0) begin
            $error("frame byte 0x%02h arrived with no query outstanding", rsp_frame_byte);
            mismatches++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== due.frame_byte) begin
               $error("frame_byte: expected 0x%02h, got 0x%02h", due.frame_byte,
                      rsp_frame_byte);
               mismatches++;
            end
            if (rsp_last !== due.last) begin
               $error("last: expected %0b, got %0b", due.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: give up when no item has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("No item moved for %0d cycles; giving up.", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Typed heads list byte 13 first and the sync byte last.
      add_row('{LAYOUT_EMPTY, 8'h00, 8'h00, 32'h0, 32'h0, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0,
                4'd0, 9'd0}, 1'b1, {{11{8'h00}}, 8'h00, 8'h00, SYNC_BYTE});
      add_row('{LAYOUT_EMPTY, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 6'h3F,
                5'h1F, 3'h7, 5'h1F, 4'hF, 9'h1FF}, 1'b1,
              {{11{8'h00}}, 8'hFF, 8'hFF, SYNC_BYTE});
      add_row('{LAYOUT_ID_ATTRS, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0,
                5'd0, 3'd0, 5'd0, 4'd0, 9'd0}, 1'b1,
              {{3{8'h00}}, {8{8'hFF}}, 8'hFF, 8'hFF, SYNC_BYTE});
      add_row('{LAYOUT_ID_ATTRS, 8'h01, 8'h80, 32'h0, 32'h0, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0,
                4'd0, 9'd0}, 1'b1, {{11{8'h00}}, 8'h01, 8'h80, SYNC_BYTE});
      add_row('{LAYOUT_ID_ATTRS, 8'h3C, 8'h5A, 32'h0123_4567, 32'h89AB_CDEF, 6'd0, 6'd0,
                5'd0, 3'd0, 5'd0, 4'd0, 9'd0}, 1'b1,
              {{3{8'h00}}, 8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01,
               8'h3C, 8'h5A, SYNC_BYTE});
      add_row('{LAYOUT_ID_ONLY, 8'h7E, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0,
                5'd0, 3'd0, 5'd0, 4'd0, 9'd0}, 1'b1,
              {{7{8'h00}}, {4{8'hFF}}, 8'h7E, 8'h01, SYNC_BYTE});
      add_row('{LAYOUT_ID_ONLY, 8'h00, 8'hFF, 32'h0, 32'hA5A5_A5A5, 6'd0, 6'd0, 5'd0, 3'd0,
                5'd0, 4'd0, 9'd0}, 1'b1, {{11{8'h00}}, 8'h00, 8'hFF, SYNC_BYTE});
      // Date and time at the top and bottom of their legal ranges.
      add_row('{LAYOUT_DATETIME, 8'h10, 8'h20, 32'h0, 32'h0, 6'd59, 6'd59, 5'd23, 3'd6,
                5'd31, 4'd11, 9'd355}, 1'b1,
              {{4{8'h00}}, 8'hFF, 8'h0C, 8'h1F, 8'h06, 8'h17, 8'h3B, 8'h3B, 8'h10, 8'h20,
               SYNC_BYTE});
      add_row('{LAYOUT_DATETIME, 8'h00, 8'h00, 32'h0, 32'h0, 6'd0, 6'd0, 5'd0, 3'd0, 5'd1,
                4'd0, 9'd100}, 1'b1,
              {{4{8'h00}}, 8'h00, 8'h01, 8'h01, {4{8'h00}}, 8'h00, 8'h00, SYNC_BYTE});
      // Every field bit set: month fifteen and the year wrapping past the top.
      add_row('{LAYOUT_DATETIME, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 6'h3F,
                5'h1F, 3'h7, 5'h1F, 4'hF, 9'h1FF}, 1'b1,
              {{4{8'h00}}, 8'h9B, 8'h10, 8'h1F, 8'h07, 8'h1F, 8'h3F, 8'h3F, 8'hFF, 8'hFF,
               SYNC_BYTE});
      // Year zero and month twelve, both out of range.
      add_row('{LAYOUT_DATETIME, 8'h55, 8'hAA, 32'h0, 32'h0, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0,
                4'd12, 9'd0}, 1'b1,
              {{4{8'h00}}, 8'h9C, 8'h0D, {5{8'h00}}, 8'h55, 8'hAA, SYNC_BYTE});
      // Year just below the range wraps to the top byte value.
      add_row('{LAYOUT_DATETIME, 8'hC3, 8'h3C, 32'h0, 32'h0, 6'd30, 6'd15, 5'd12, 3'd3,
                5'd15, 4'd0, 9'd99}, 1'b1,
              {{4{8'h00}}, 8'hFF, 8'h01, 8'h0F, 8'h03, 8'h0C, 8'h0F, 8'h1E, 8'hC3, 8'h3C,
               SYNC_BYTE});
      add_row('{LAYOUT_DATETIME, 8'h81, 8'h42, 32'hDEAD_BEEF, 32'h1234_5678, 6'd7, 6'd45,
                5'd9, 3'd2, 5'd28, 4'd1, 9'd356}, 1'b0, '0);
      add_row('{LAYOUT_EMPTY, 8'h5A, 8'hA5, 32'h8000_0001, 32'h7FFF_FFFE, 6'h2A, 6'h15,
                5'h0A, 3'h5, 5'h15, 4'h5, 9'h0AA}, 1'b0, '0);
      add_row('{LAYOUT_ID_ATTRS, 8'hAA, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA, 6'd0, 6'd0,
                5'd0, 3'd0, 5'd0, 4'd0, 9'd0}, 1'b0, '0);

      // Hold reset while every input is at a known value.
      reset     <= 1'b1;
      req_valid <= 1'b0;
      drive_fields(random_query());
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_query(directed_rows[i].q, directed_rows[i].has_head, directed_rows[i].head);
      end

      // Random queries, with one stretch where neither side idles.
      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         steady <= (n >= 120 && n < 170);
         send_query(random_query(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Let the remaining frames drain, then watch for stray bytes.
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d queries (%0d directed) over all four payload layouts.",
               queries_sent, directed_rows.size());
      $display("Checked %0d frame bytes in %0d frames; %0d mismatches.",
               bytes_checked, frames_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
